[design/rtbm_pkg.sv]
package rtbm_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int PORTS       = 8;

	localparam int KEY_W   = 32;
	localparam int IFACE_W = 3;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int PC_W    = $clog2(PORTS + 1);
	localparam int ENTRY_W = KEY_W + IFACE_W;

	localparam logic [MODE_W-1:0] MODE_LOOKUP    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_ROUTE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REBIND    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ADD_IFACE = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNDELIVERABLE = 2'd1;
	localparam logic [STAT_W-1:0] ST_TABLE_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] ST_NO_PORT       = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last;
	} stat_t;

endpackage

[design/rtbm_ram.sv]
module rtbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/rtbm_ctrl.sv]
module rtbm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rtbm_pkg::stat_t stat,
	output rtbm_pkg::cmd_t  cmd,
	output logic          busy
);

	rtbm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtbm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.rd     = 1'b0;
		cmd.finish = 1'b0;
		busy       = 1'b1;
		case (state_q)
			rtbm_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = rtbm_pkg::S_SCAN;
				end
			end
			rtbm_pkg::S_SCAN: begin
				cmd.rd = 1'b1;
				if (stat.last) begin
					state_d = rtbm_pkg::S_DRAIN;
				end
			end
			// last entry's read data is evaluated here
			rtbm_pkg::S_DRAIN: begin
				state_d = rtbm_pkg::S_FINISH;
			end
			rtbm_pkg::S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = rtbm_pkg::S_IDLE;
			end
			default: begin
				state_d = rtbm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[design/rtbm_dp.sv]
module rtbm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rtbm_pkg::cmd_t                cmd,
	output rtbm_pkg::stat_t               stat,
	input  logic [rtbm_pkg::MODE_W-1:0]   mode,
	input  logic [rtbm_pkg::KEY_W-1:0]    address,
	input  logic [rtbm_pkg::IFACE_W-1:0]  iface,
	output logic                          done,
	output logic [rtbm_pkg::STAT_W-1:0]   status,
	output logic [rtbm_pkg::IFACE_W-1:0]  out_iface,
	output logic [rtbm_pkg::KEY_W-1:0]    matched_key
);

	localparam int IDX_W   = rtbm_pkg::IDX_W;
	localparam int KEY_W   = rtbm_pkg::KEY_W;
	localparam int IFACE_W = rtbm_pkg::IFACE_W;
	localparam int PC_W    = rtbm_pkg::PC_W;

	// latched item
	logic [rtbm_pkg::MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]            addr_q;
	logic [IFACE_W-1:0]          iface_q;

	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_s1;
	logic             ev_s1;

	logic [rtbm_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [PC_W-1:0]                  pc_q;

	logic               found_q;
	logic [KEY_W-1:0]   best_score_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [IFACE_W-1:0] best_port_q;
	logic               match_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic [rtbm_pkg::ENTRY_W-1:0] rdata;
	logic [KEY_W-1:0]             key_rd;
	logic [IFACE_W-1:0]           port_rd;
	logic                         vld_rd;
	logic                         drop;
	logic                         eff;
	logic                         eligible;
	logic [KEY_W-1:0]             score;
	logic                         better;

	logic                         fin_wr;
	logic                         fin_new;
	logic                         fin_pc_inc;
	logic [IDX_W-1:0]             fin_addr;
	logic [rtbm_pkg::STAT_W-1:0]  fin_status;
	logic [IFACE_W-1:0]           fin_iface;
	logic [KEY_W-1:0]             fin_key;
	logic [IFACE_W-1:0]           wr_port;
	logic                         pc_full;

	rtbm_ram #(
		.WIDTH(rtbm_pkg::ENTRY_W),
		.DEPTH(rtbm_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.finish && fin_wr),
		.waddr(fin_addr),
		.wdata({wr_port, addr_q}),
		.raddr(cnt_q),
		.rdata(rdata)
	);

	assign stat.last = (cnt_q == IDX_W'(rtbm_pkg::TABLE_DEPTH - 1));

	assign key_rd   = rdata[KEY_W-1:0];
	assign port_rd  = rdata[rtbm_pkg::ENTRY_W-1:KEY_W];
	assign vld_rd   = valid_q[idx_s1];
	assign drop     = (mode_q == rtbm_pkg::MODE_REBIND) && (port_rd == iface_q);
	assign eff      = vld_rd && !drop;
	assign eligible = vld_rd && (port_rd != iface_q);
	assign score    = addr_q & key_rd;
	assign better   = !found_q || (score > best_score_q) ||
		((score == best_score_q) && (key_rd < best_key_q));

	assign pc_full = (pc_q >= PC_W'(rtbm_pkg::PORTS));
	assign wr_port = (mode_q == rtbm_pkg::MODE_ADD_IFACE) ? IFACE_W'(pc_q) : iface_q;

	always_comb begin
		fin_wr     = 1'b0;
		fin_new    = 1'b0;
		fin_pc_inc = 1'b0;
		fin_addr   = match_q ? match_idx_q : free_idx_q;
		fin_status = rtbm_pkg::ST_OK;
		fin_iface  = '0;
		fin_key    = '0;
		case (mode_q)
			rtbm_pkg::MODE_LOOKUP: begin
				if (found_q) begin
					fin_iface = best_port_q;
					fin_key   = best_key_q;
				end else begin
					fin_status = rtbm_pkg::ST_UNDELIVERABLE;
				end
			end
			rtbm_pkg::MODE_ADD_IFACE: begin
				if (pc_full) begin
					fin_status = rtbm_pkg::ST_NO_PORT;
				end else if (!match_q && !free_q) begin
					fin_status = rtbm_pkg::ST_TABLE_FULL;
				end else begin
					fin_wr     = 1'b1;
					fin_new    = !match_q;
					fin_pc_inc = 1'b1;
					fin_iface  = IFACE_W'(pc_q);
				end
			end
			default: begin
				if (!match_q && !free_q) begin
					fin_status = rtbm_pkg::ST_TABLE_FULL;
				end else begin
					fin_wr  = 1'b1;
					fin_new = !match_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			addr_q  <= address;
			iface_q <= iface;
		end
		idx_s1 <= cnt_q;
		if (ev_s1) begin
			if (mode_q == rtbm_pkg::MODE_LOOKUP) begin
				if (eligible && better) begin
					best_score_q <= score;
					best_key_q   <= key_rd;
					best_port_q  <= port_rd;
				end
			end else begin
				if (eff && (key_rd == addr_q) && !match_q) begin
					match_idx_q <= idx_s1;
				end
				if (!eff && !free_q) begin
					free_idx_q <= idx_s1;
				end
			end
		end
		if (cmd.finish) begin
			status      <= fin_status;
			out_iface   <= fin_iface;
			matched_key <= fin_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ev_s1   <= 1'b0;
			valid_q <= '0;
			pc_q    <= '0;
			found_q <= 1'b0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			ev_s1 <= cmd.rd;
			done  <= cmd.finish;
			if (cmd.load) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (cmd.rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ev_s1) begin
				if (mode_q == rtbm_pkg::MODE_LOOKUP) begin
					if (eligible && better) begin
						found_q <= 1'b1;
					end
				end else begin
					if (eff && (key_rd == addr_q)) begin
						match_q <= 1'b1;
					end
					if (!eff) begin
						free_q <= 1'b1;
					end
				end
				// drop the old routes of a rebound interface
				if (vld_rd && drop) begin
					valid_q[idx_s1] <= 1'b0;
				end
			end
			if (cmd.finish) begin
				if (fin_wr && fin_new) begin
					valid_q[fin_addr] <= 1'b1;
				end
				if (fin_pc_inc) begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

endmodule

[design/route_table_best_match_top.sv]
// Route table with best-match lookup.
// Input channel: an item (mode, address, iface) is taken at a rising edge
// where start is high and busy is low. Modes: lookup, add route, rebind
// an interface to a new address, add an interface.
// Result channel: done is high for exactly one cycle with status,
// out_iface and matched_key valid in that cycle. One result per item.
// Timing: every item walks the whole table one entry per cycle through the
// single read port of the entry memory; a drain state and a finish state
// follow the scan, and the finish state writes the table and registers the
// result. done follows in the next cycle, in which busy is already low and
// a new item may start. A new item is taken only once the previous one is
// finished and the block is back in idle.
// Reset (arst_n low) clears all route valid bits and the interface count,
// so the table starts empty; no clearing pass is needed.
// The receiver cannot stall: results are not held, done is a strobe.
module route_table_best_match_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [rtbm_pkg::MODE_W-1:0]  mode,
	input  logic [rtbm_pkg::KEY_W-1:0]   address,
	input  logic [rtbm_pkg::IFACE_W-1:0] iface,
	output logic                         done,
	output logic [rtbm_pkg::STAT_W-1:0]  status,
	output logic [rtbm_pkg::IFACE_W-1:0] out_iface,
	output logic [rtbm_pkg::KEY_W-1:0]   matched_key
);

	rtbm_pkg::cmd_t  cmd;
	rtbm_pkg::stat_t stat;

	rtbm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	rtbm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.address    (address),
		.iface      (iface),
		.done       (done),
		.status     (status),
		.out_iface  (out_iface),
		.matched_key(matched_key)
	);

endmodule

[tb/route_table_best_match_top_tb.sv]
module route_table_best_match_top_tb;

	typedef struct packed {
		logic [rtbm_pkg::STAT_W-1:0]  st;
		logic [rtbm_pkg::IFACE_W-1:0] port;
		logic [rtbm_pkg::KEY_W-1:0]   key;
	} answer_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [rtbm_pkg::MODE_W-1:0]   mode;
	logic [rtbm_pkg::KEY_W-1:0]    address;
	logic [rtbm_pkg::IFACE_W-1:0]  iface;
	logic                          done;
	logic [rtbm_pkg::STAT_W-1:0]   status;
	logic [rtbm_pkg::IFACE_W-1:0]  out_iface;
	logic [rtbm_pkg::KEY_W-1:0]    matched_key;

	// predictor copy of the route table
	logic                          rt_valid [rtbm_pkg::TABLE_DEPTH];
	logic [rtbm_pkg::KEY_W-1:0]    rt_key   [rtbm_pkg::TABLE_DEPTH];
	logic [rtbm_pkg::IFACE_W-1:0]  rt_port  [rtbm_pkg::TABLE_DEPTH];
	int                            iface_count;

	answer_t                       pending_answers [$];
	logic [rtbm_pkg::KEY_W-1:0]    key_pool [24];
	int                            errors;

	route_table_best_match_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.address     (address),
		.iface       (iface),
		.done        (done),
		.status      (status),
		.out_iface   (out_iface),
		.matched_key (matched_key)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string what,
			input logic [rtbm_pkg::KEY_W-1:0] got,
			input logic [rtbm_pkg::KEY_W-1:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic logic [rtbm_pkg::STAT_W-1:0] store_route(
			input logic [rtbm_pkg::KEY_W-1:0] key,
			input logic [rtbm_pkg::IFACE_W-1:0] port);
		int slot = -1;
		for (int i = 0; i < rtbm_pkg::TABLE_DEPTH; i++) begin
			if (rt_valid[i]) begin
				if (rt_key[i] == key) begin
					rt_port[i] = port;
					return rtbm_pkg::ST_OK;
				end
			end else if (slot < 0) begin
				slot = i;
			end
		end
		if (slot < 0)
			return rtbm_pkg::ST_TABLE_FULL;
		rt_valid[slot] = 1'b1;
		rt_key[slot]   = key;
		rt_port[slot]  = port;
		return rtbm_pkg::ST_OK;
	endfunction

	function automatic answer_t predict_answer(input logic [rtbm_pkg::MODE_W-1:0] m,
			input logic [rtbm_pkg::KEY_W-1:0] addr,
			input logic [rtbm_pkg::IFACE_W-1:0] src);
		answer_t                      a;
		logic                         found;
		logic                         present;
		logic                         have_free;
		logic [rtbm_pkg::KEY_W-1:0]   score;
		logic [rtbm_pkg::KEY_W-1:0]   best_score;
		logic [rtbm_pkg::KEY_W-1:0]   best_key;
		logic [rtbm_pkg::IFACE_W-1:0] best_port;
		a = '{st: rtbm_pkg::ST_OK, port: '0, key: '0};
		found = 1'b0;
		best_score = '0;
		best_key = '0;
		best_port = '0;
		case (m)
			rtbm_pkg::MODE_LOOKUP: begin
				for (int i = 0; i < rtbm_pkg::TABLE_DEPTH; i++) begin
					if (rt_valid[i] && rt_port[i] != src) begin
						score = addr & rt_key[i];
						if (!found || score > best_score ||
								(score == best_score && rt_key[i] < best_key)) begin
							found = 1'b1;
							best_score = score;
							best_key = rt_key[i];
							best_port = rt_port[i];
						end
					end
				end
				if (found) begin
					a.port = best_port;
					a.key = best_key;
				end else begin
					a.st = rtbm_pkg::ST_UNDELIVERABLE;
				end
			end
			rtbm_pkg::MODE_ADD_ROUTE: a.st = store_route(addr, src);
			rtbm_pkg::MODE_REBIND: begin
				// drop old routes first, even if the new key then finds no slot
				for (int i = 0; i < rtbm_pkg::TABLE_DEPTH; i++)
					if (rt_valid[i] && rt_port[i] == src)
						rt_valid[i] = 1'b0;
				a.st = store_route(addr, src);
			end
			default: begin
				present = 1'b0;
				have_free = 1'b0;
				for (int i = 0; i < rtbm_pkg::TABLE_DEPTH; i++) begin
					if (!rt_valid[i])
						have_free = 1'b1;
					else if (rt_key[i] == addr)
						present = 1'b1;
				end
				if (iface_count >= rtbm_pkg::PORTS) begin
					a.st = rtbm_pkg::ST_NO_PORT;
				end else if (!present && !have_free) begin
					a.st = rtbm_pkg::ST_TABLE_FULL;
				end else begin
					a.st = store_route(addr, iface_count[rtbm_pkg::IFACE_W-1:0]);
					a.port = iface_count[rtbm_pkg::IFACE_W-1:0];
					iface_count++;
				end
			end
		endcase
		return a;
	endfunction

	// Drive one item after a gap of idle cycles; predict it at the accepting edge.
	task automatic send_item(input logic [rtbm_pkg::MODE_W-1:0] item_mode,
			input logic [rtbm_pkg::KEY_W-1:0] item_addr,
			input logic [rtbm_pkg::IFACE_W-1:0] item_iface,
			input int gap);
		answer_t expected;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start   <= 1'b1;
		mode    <= item_mode;
		address <= item_addr;
		iface   <= item_iface;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected = predict_answer(item_mode, item_addr, item_iface);
		pending_answers = {pending_answers, expected};
	endtask

	// Hold start low until every pending answer is in, then let the block settle.
	task automatic drain_answers();
		@(negedge clk);
		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic random_item(input bit idle);
		int                           r;
		int                           gap;
		logic [rtbm_pkg::MODE_W-1:0]  m;
		logic [rtbm_pkg::KEY_W-1:0]   a;
		logic [rtbm_pkg::IFACE_W-1:0] p;
		r = $urandom_range(0, 99);
		gap = idle ? $urandom_range(0, 19) : 0;
		p = rtbm_pkg::IFACE_W'($urandom_range(0, 7));
		if (r < 10) begin
			m = rtbm_pkg::MODE_W'($urandom);
			a = $urandom;
		end else begin
			if (r < 50)
				m = rtbm_pkg::MODE_LOOKUP;
			else if (r < 73)
				m = rtbm_pkg::MODE_ADD_ROUTE;
			else if (r < 92)
				m = rtbm_pkg::MODE_REBIND;
			else
				m = rtbm_pkg::MODE_ADD_IFACE;
			a = key_pool[$urandom_range(0, 23)];
			case ($urandom_range(0, 3))
				0: a = $urandom;
				1: if (m == rtbm_pkg::MODE_LOOKUP) a = a | $urandom;
				default: ;
			endcase
		end
		send_item(m, a, p, gap);
	endtask

	task automatic test_directed();
		send_item(rtbm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 3'd0, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_ADD_IFACE, 32'h0000_0000, 3'd7, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_ADD_IFACE, 32'hFFFF_FFFF, 3'd0, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 3'd0, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_LOOKUP, 32'h0000_0000, 3'd7, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 3'd1, $urandom_range(0, 19));
		// rebind an interface that was never assigned
		send_item(rtbm_pkg::MODE_REBIND, 32'h8000_0000, 3'd6, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_ADD_ROUTE, 32'hFFFF_FFFF, 3'd7, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_ADD_IFACE, 32'h8000_0000, 3'd5, $urandom_range(0, 19));
		for (int i = 0; i < 13; i++)
			send_item(rtbm_pkg::MODE_ADD_ROUTE, 32'h0100_0000 * (i + 1) + i, i[2:0],
				$urandom_range(0, 19));
		// table is full now
		send_item(rtbm_pkg::MODE_ADD_ROUTE, 32'h1234_5678, 3'd4, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_ADD_IFACE, 32'hDEAD_BEEF, 3'd0, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_REBIND, 32'h5555_AAAA, 3'd2, $urandom_range(0, 19));
		send_item(rtbm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 3'd7, $urandom_range(0, 19));
	endtask

	task automatic test_random_idle(input int n);
		for (int i = 0; i < n; i++)
			random_item(1'b1);
	endtask

	task automatic test_random_back_to_back(input int n);
		for (int i = 0; i < n; i++)
			random_item(1'b0);
	endtask

	task automatic test_drained_restart(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				drain_answers();
			random_item(i % 100 < 50);
		end
	endtask

	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("result with nothing pending", {30'b0, status}, '0);
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.st)
					report_mismatch("status", {30'b0, status}, {30'b0, want.st});
				if (out_iface !== want.port)
					report_mismatch("out_iface", {29'b0, out_iface}, {29'b0, want.port});
				if (matched_key !== want.key)
					report_mismatch("matched_key", matched_key, want.key);
			end
		end
	end

	initial begin
		errors = 0;
		iface_count = 0;
		for (int i = 0; i < rtbm_pkg::TABLE_DEPTH; i++) begin
			rt_valid[i] = 1'b0;
			rt_key[i] = '0;
			rt_port[i] = '0;
		end
		// mix of edge keys, prefix-like keys and random keys
		for (int i = 0; i < 24; i++) begin
			case (i % 4)
				0: key_pool[i] = {8'($urandom_range(0, 255)), 24'h0};
				1: key_pool[i] = {16'($urandom_range(0, 65535)), 16'h0};
				default: key_pool[i] = $urandom;
			endcase
		end
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		arst_n  = 1'b0;
		start   = 1'b0;
		mode    = rtbm_pkg::MODE_LOOKUP;
		address = '0;
		iface   = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_idle(700);
		test_random_back_to_back(300);
		test_drained_restart(500);
		drain_answers();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
